@@ sv/kmer_count_canonical_histogram_defines.svh @@
// ----------------------------------------------------------------------------
// K-mer counter assertion macros
// Concurrent assertion forms for the k-mer counter datapath.
// ----------------------------------------------------------------------------
`ifndef KMER_COUNT_CANONICAL_HISTOGRAM_DEFINES_SVH
`define KMER_COUNT_CANONICAL_HISTOGRAM_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define KCCH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define KCCH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/kcch_pkg.sv @@
// ----------------------------------------------------------------------------
// K-mer counter package
// Types, constants and helper functions shared by the k-mer counter modules.
// ----------------------------------------------------------------------------
package kcch_pkg;

    localparam int MAX_KMER  = 8;
    localparam int KMER_W    = 2 * MAX_KMER;
    localparam int K_W       = 4;
    localparam int CNT_W     = 8;
    localparam int HIST_BINS = 256;
    localparam int HIST_AW   = $clog2(HIST_BINS);
    localparam int HIST_W    = 17;
    localparam int TOTAL_W   = 48;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 104;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_BASE     = 2'd0,
        OP_COMBINE  = 2'd1,
        OP_READ_BIN = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE_RD,
        S_BASE_WR,
        S_CMB_START,
        S_CMB_RD_I,
        S_CMB_CHK,
        S_CMB_RD_RC,
        S_CMB_MATE,
        S_CMB_ZERO,
        S_HIST_RD,
        S_HIST_WR,
        S_CMB_NEXT,
        S_BIN_RD,
        S_BIN_CAP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_wr;
        logic idx_inc;
        logic base_rd;
        logic base_wr;
        logic cmb_start;
        logic rd_idx;
        logic chk;
        logic rd_rc;
        logic mate;
        logic zero_rc;
        logic hist_rd;
        logic hist_wr;
        logic bin_rd;
        logic bin_cap;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic idx_last;
        logic counted;
        logic cnt_zero;
        logic merge;
        logic skip;
        logic out_free;
    } status_t;

    function automatic logic [K_W-1:0] eff_size(input logic [K_W-1:0] k);
        logic [K_W-1:0] r;
        r = k;
        if (k == '0)
        begin
            r = K_W'(1);
        end
        else if (k > K_W'(MAX_KMER))
        begin
            r = K_W'(MAX_KMER);
        end
        return r;
    endfunction

    function automatic logic [KMER_W-1:0] size_mask(input logic [K_W-1:0] k);
        logic [KMER_W-1:0] m;
        m = '0;
        for (int j = 0; j < MAX_KMER; j++)
        begin
            if (K_W'(j) < k)
            begin
                m[2*j +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

    function automatic logic [KMER_W-1:0] rev_comp(input logic [KMER_W-1:0] v,
                                                   input logic [K_W-1:0] k);
        logic [KMER_W-1:0] r;
        r = '0;
        for (int j = 0; j < MAX_KMER; j++)
        begin
            if (K_W'(j) < k)
            begin
                r = {r[KMER_W-3:0], ~v[2*j +: 2]};
            end
        end
        return r;
    endfunction

endpackage

@@ sv/kmer_count_canonical_histogram.sv @@
// ----------------------------------------------------------------------------
// K-mer counter top level
// Canonical k-mer counting with saturating counters and a count histogram.
//
// Channel  Dir  tdata (low bit up)                           tuser
// s_*      in   base, read_start, bin_index                  op
// m_*      out  kmer_value, bin_count, distinct, total       kmer_valid
// cfg_*    in   kmer_size                                    -
//
// Bases, bin reads and combine passes are stepped by the controller sequence,
// with at most one count table access per step.
// After reset the table is cleared one entry a cycle, all 65536 of them;
// no word is accepted until that finishes.
// A result waits in an output register; the next word is accepted meanwhile.
// ----------------------------------------------------------------------------
module kmer_count_canonical_histogram
    import kcch_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [K_W-1:0]        cfg_wr_data,  // kmer_size
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,      // base, read_start, bin_index
    input  logic [1:0]            s_tuser,      // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,      // kmer_value, bin_count,
                                                // distinct_kmers, total_kmers
    output logic                  m_tuser       // kmer_valid
);

    cmd_t    cmd;
    status_t st;

    kcch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_op    (op_t'(s_tuser)),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    kcch_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

@@ sv/kcch_ctrl.sv @@
// ----------------------------------------------------------------------------
// K-mer counter controller
// Sequences base updates, the combine pass, bin reads and the table clear.
// ----------------------------------------------------------------------------
module kcch_ctrl
    import kcch_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  op_t     in_op,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_op)
                        OP_BASE:     state_next = S_BASE_RD;
                        OP_COMBINE:  state_next = S_CMB_START;
                        OP_READ_BIN: state_next = S_BIN_RD;
                        default:     state_next = S_OUT;
                    endcase
                end
            end
            S_BASE_RD:   state_next = st.counted ? S_BASE_WR : S_OUT;
            S_BASE_WR:   state_next = S_OUT;
            S_CMB_START: state_next = S_CMB_RD_I;
            S_CMB_RD_I:  state_next = S_CMB_CHK;
            S_CMB_CHK:   state_next = st.cnt_zero ? S_CMB_NEXT : S_CMB_RD_RC;
            S_CMB_RD_RC: state_next = S_CMB_MATE;
            S_CMB_MATE:
            begin
                if (st.merge)
                begin
                    state_next = S_CMB_ZERO;
                end
                else if (st.skip)
                begin
                    state_next = S_CMB_NEXT;
                end
                else
                begin
                    state_next = S_HIST_RD;
                end
            end
            S_CMB_ZERO:  state_next = S_HIST_RD;
            S_HIST_RD:   state_next = S_HIST_WR;
            S_HIST_WR:   state_next = S_CMB_NEXT;
            S_CMB_NEXT:  state_next = st.idx_last ? S_OUT : S_CMB_RD_I;
            S_BIN_RD:    state_next = S_BIN_CAP;
            S_BIN_CAP:   state_next = S_OUT;
            S_OUT:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_BASE_RD:   cmd.base_rd   = 1'b1;
            S_BASE_WR:   cmd.base_wr   = 1'b1;
            S_CMB_START: cmd.cmb_start = 1'b1;
            S_CMB_RD_I:  cmd.rd_idx    = 1'b1;
            S_CMB_CHK:   cmd.chk       = 1'b1;
            S_CMB_RD_RC: cmd.rd_rc     = 1'b1;
            S_CMB_MATE:  cmd.mate      = 1'b1;
            S_CMB_ZERO:  cmd.zero_rc   = 1'b1;
            S_HIST_RD:   cmd.hist_rd   = 1'b1;
            S_HIST_WR:   cmd.hist_wr   = 1'b1;
            S_CMB_NEXT:  cmd.idx_inc   = !st.idx_last;
            S_BIN_RD:    cmd.bin_rd    = 1'b1;
            S_BIN_CAP:   cmd.bin_cap   = 1'b1;
            S_OUT:       cmd.load_out  = st.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

@@ sv/kcch_dp.sv @@
// ----------------------------------------------------------------------------
// K-mer counter datapath
// Count table, histogram memory, rolling k-mer, totals and output register.
// ----------------------------------------------------------------------------
`include "kmer_count_canonical_histogram_defines.svh"

module kcch_dp
    import kcch_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [K_W-1:0]        cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    input  cmd_t                  cmd,
    output status_t               st
);

    logic [K_W-1:0]     kmer_size_reg;
    logic [KMER_W-1:0]  rolling_reg;
    logic [K_W-1:0]     bases_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [HIST_W-1:0]  distinct_reg;
    logic [HIST_AW-1:0] bin_reg;
    logic [KMER_W-1:0]  idx_reg;
    logic [KMER_W-1:0]  rc_reg;
    logic [CNT_W-1:0]   add_reg;
    logic               res_valid_reg;
    logic [KMER_W-1:0]  res_value_reg;
    logic [HIST_W-1:0]  res_bin_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               out_user_reg;

    logic [CNT_W-1:0]   tbl_mem [2**KMER_W];
    logic [CNT_W-1:0]   tbl_rd_reg;
    logic [HIST_W-1:0]  hist_mem [HIST_BINS];
    logic [HIST_W-1:0]  hist_rd_reg;
    logic               hist_hit_reg;
    logic [HIST_BINS-1:0] hist_valid_reg;

    logic [K_W-1:0]     k_eff;
    logic [KMER_W-1:0]  k_mask;
    logic [KMER_W-1:0]  kmer_addr;
    logic [KMER_W-1:0]  tbl_ra;
    logic [KMER_W-1:0]  tbl_wa;
    logic [CNT_W-1:0]   tbl_wd;
    logic               tbl_we;
    logic [CNT_W:0]     sum_wide;
    logic [CNT_W-1:0]   sum_sat;
    logic [HIST_AW-1:0] hist_ra;
    logic               in_start;
    logic [1:0]         in_base;

    assign k_eff     = eff_size(kmer_size_reg);
    assign k_mask    = size_mask(k_eff);
    assign kmer_addr = rolling_reg & k_mask;
    assign in_base   = s_tdata[1:0];
    assign in_start  = s_tdata[2];
    assign sum_wide  = {1'b0, add_reg} + {1'b0, tbl_rd_reg};
    assign sum_sat   = sum_wide[CNT_W] ? COUNT_MAX : sum_wide[CNT_W-1:0];

    assign st.clear_last = (idx_reg == '1);
    assign st.idx_last   = (idx_reg == k_mask);
    assign st.counted    = (bases_reg >= k_eff);
    assign st.cnt_zero   = (tbl_rd_reg == '0);
    assign st.merge      = (idx_reg < rc_reg) && (tbl_rd_reg != '0);
    assign st.skip       = (idx_reg > rc_reg) && (tbl_rd_reg != '0);
    assign st.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        tbl_ra = idx_reg;
        if (cmd.base_rd)
        begin
            tbl_ra = kmer_addr;
        end
        else if (cmd.rd_rc)
        begin
            tbl_ra = rc_reg;
        end
        else if (cmd.rd_idx)
        begin
            tbl_ra = idx_reg;
        end
    end

    always_comb
    begin
        tbl_we = 1'b0;
        tbl_wa = idx_reg;
        tbl_wd = '0;
        if (cmd.clr_wr)
        begin
            tbl_we = 1'b1;
        end
        else if (cmd.base_wr)
        begin
            tbl_we = 1'b1;
            tbl_wa = kmer_addr;
            tbl_wd = (tbl_rd_reg == COUNT_MAX) ? COUNT_MAX : tbl_rd_reg + CNT_W'(1);
        end
        else if (cmd.mate && st.merge)
        begin
            tbl_we = 1'b1;
            tbl_wd = sum_sat;
        end
        else if (cmd.zero_rc)
        begin
            tbl_we = 1'b1;
            tbl_wa = rc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_rd_reg <= tbl_mem[tbl_ra];
    end

    assign hist_ra = cmd.hist_rd ? add_reg : bin_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.hist_wr)
        begin
            hist_mem[add_reg] <= (hist_hit_reg ? hist_rd_reg : '0) + HIST_W'(1);
        end
        hist_rd_reg  <= hist_mem[hist_ra];
        hist_hit_reg <= hist_valid_reg[hist_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_size_reg  <= K_W'(MAX_KMER);
            rolling_reg    <= '0;
            bases_reg      <= '0;
            total_reg      <= '0;
            distinct_reg   <= '0;
            idx_reg        <= '0;
            hist_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                kmer_size_reg <= cfg_wr_data;
            end
            if (cmd.load_in && (op_t'(s_tuser) == OP_BASE))
            begin
                if (in_start)
                begin
                    rolling_reg <= KMER_W'(in_base);
                    bases_reg   <= K_W'(1);
                end
                else
                begin
                    rolling_reg <= {rolling_reg[KMER_W-3:0], in_base};
                    if (bases_reg != '1)
                    begin
                        bases_reg <= bases_reg + K_W'(1);
                    end
                end
            end
            if (cmd.base_wr && (total_reg != '1))
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end
            if (cmd.cmb_start)
            begin
                distinct_reg   <= '0;
                hist_valid_reg <= '0;
                idx_reg        <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + KMER_W'(1);
            end
            if (cmd.hist_wr)
            begin
                distinct_reg            <= distinct_reg + HIST_W'(1);
                hist_valid_reg[add_reg] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            bin_reg       <= s_tdata[10:3];
            res_valid_reg <= 1'b0;
            res_value_reg <= '0;
            res_bin_reg   <= '0;
        end
        if (cmd.base_wr)
        begin
            res_valid_reg <= 1'b1;
            res_value_reg <= kmer_addr;
        end
        if (cmd.bin_cap)
        begin
            res_bin_reg <= hist_hit_reg ? hist_rd_reg : '0;
        end
        if (cmd.chk)
        begin
            add_reg <= tbl_rd_reg;
            rc_reg  <= rev_comp(idx_reg, k_eff);
        end
        if (cmd.mate && st.merge)
        begin
            add_reg <= sum_sat;
        end
        if (cmd.load_out)
        begin
            out_user_reg <= res_valid_reg;
            out_data_reg <= {6'd0, total_reg, distinct_reg, res_bin_reg, res_value_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `KCCH_ASSERT_NEXT(a_total_mono, 1'b1, total_reg >= $past(total_reg),
        "Occurrence total decreased.")
    `KCCH_ASSERT_IMPL(a_count_ok, cmd.base_wr, bases_reg >= k_eff,
        "Counter update for an incomplete k-mer.")
    `KCCH_ASSERT_IMPL(a_zero_after_merge, cmd.zero_rc, $past(cmd.mate),
        "Complement cleared without a merge.")
    `KCCH_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid_reg || m_tready,
        "Result loaded over an untaken word.")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// K-mer counter testbench
// Streams bases, combine passes and bin reads into the counter, predicts each
// result word with a local model of the count table and histogram, and checks
// every output word in order under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import kcch_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [K_W-1:0]        cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    typedef struct packed {
        logic        kmer_valid;
        logic [15:0] kmer_value;
        logic [16:0] bin_count;
        logic [16:0] distinct_kmers;
        logic [47:0] total_kmers;
    } kmer_result_t;

    logic [7:0]  counts [0:65535];
    logic [16:0] freq_bins [0:255];
    logic [15:0] window;
    logic [3:0]  read_len;
    logic [47:0] occurrences;
    logic [16:0] distinct_count;
    logic [3:0]  size_reg;
    kmer_result_t pending_results [$];
    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;

    kmer_count_canonical_histogram dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    function automatic int active_size();
        if (size_reg == 4'd0)
        begin
            return 1;
        end
        if (size_reg > 4'd8)
        begin
            return 8;
        end
        return size_reg;
    endfunction

    function automatic logic [15:0] complement_of(input logic [15:0] v, input int k);
        logic [15:0] r;
        r = '0;
        for (int j = 0; j < k; j++)
        begin
            r = {r[13:0], 2'd3 - v[2*j +: 2]};
        end
        return r;
    endfunction

    task automatic merge_strands();
        int k;
        int n;
        int add;
        int mate;
        logic [15:0] rc;
        k = active_size();
        n = 1 << (2 * k);
        for (int b = 0; b < 256; b++)
        begin
            freq_bins[b] = '0;
        end
        distinct_count = '0;
        for (int i = 0; i < n; i++)
        begin
            if (counts[i] != 8'd0)
            begin
                add = counts[i];
                rc = complement_of(16'(i), k);
                mate = counts[rc];
                if (i < rc && mate > 0)
                begin
                    add = add + mate;
                    if (add > 255)
                    begin
                        add = 255;
                    end
                    counts[i] = 8'(add);
                    counts[rc] = 8'd0;
                end
                if (!(i > rc && mate > 0))
                begin
                    distinct_count = distinct_count + 17'd1;
                    freq_bins[add[7:0]] = freq_bins[add[7:0]] + 17'd1;
                end
            end
        end
    endtask

    task automatic predict_word(input op_t op, input logic [1:0] b, input logic rs,
                                input logic [7:0] bin);
        kmer_result_t r;
        logic [15:0] km;
        int k;
        r = '0;
        if (op == OP_BASE)
        begin
            k = active_size();
            if (rs)
            begin
                window = {14'd0, b};
                read_len = 4'd1;
            end
            else
            begin
                window = {window[13:0], b};
                if (read_len < 4'd15)
                begin
                    read_len = read_len + 4'd1;
                end
            end
            if (read_len >= k)
            begin
                km = window & 16'((32'd1 << (2 * k)) - 1);
                if (counts[km] < 8'd255)
                begin
                    counts[km] = counts[km] + 8'd1;
                end
                if (occurrences != '1)
                begin
                    occurrences = occurrences + 48'd1;
                end
                r.kmer_valid = 1'b1;
                r.kmer_value = km;
            end
        end
        else if (op == OP_COMBINE)
        begin
            merge_strands();
        end
        else if (op == OP_READ_BIN)
        begin
            r.bin_count = freq_bins[bin];
        end
        r.distinct_kmers = distinct_count;
        r.total_kmers = occurrences;
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic send_word(input op_t op, input logic [1:0] b, input logic rs,
                             input logic [7:0] bin);
        while (($urandom % 100) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, bin, rs, b};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_word(op, b, rs, bin);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= (($urandom % 100) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        kmer_result_t got;
        kmer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[15:0], m_tdata[32:16], m_tdata[49:33],
                   m_tdata[97:50]};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected word %h", got);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"Mismatch: valid %0d/%0d kmer %h/%h bin %0d/%0d ",
                                  "distinct %0d/%0d total %0d/%0d"},
                                 want.kmer_valid, got.kmer_valid,
                                 want.kmer_value, got.kmer_value,
                                 want.bin_count, got.bin_count,
                                 want.distinct_kmers, got.distinct_kmers,
                                 want.total_kmers, got.total_kmers);
                    end
                end
            end
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_size(input logic [3:0] k);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= k;
        size_reg = k;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic read_all_bins();
        for (int b = 0; b < 256; b += 17)
        begin
            send_word(OP_READ_BIN, 2'd0, 1'b0, 8'(b));
        end
        send_word(OP_READ_BIN, 2'd0, 1'b0, 8'd255);
    endtask

    task automatic test_directed();
        set_size(4'd2);
        send_word(OP_BASE, 2'd0, 1'b1, 8'hFF);
        send_word(OP_BASE, 2'd3, 1'b0, 8'd0);
        send_word(OP_BASE, 2'd3, 1'b0, 8'd0);
        send_word(OP_BASE, 2'd0, 1'b0, 8'd0);
        send_word(OP_BASE, 2'd1, 1'b1, 8'd0);
        send_word(OP_BASE, 2'd2, 1'b0, 8'd0);
        send_word(OP_BASE, 2'd1, 1'b0, 8'd0);
        send_word(OP_NONE, 2'd3, 1'b1, 8'hAA);
        send_word(OP_COMBINE, 2'd0, 1'b0, 8'd0);
        send_word(OP_COMBINE, 2'd0, 1'b0, 8'd0);
        send_word(OP_READ_BIN, 2'd0, 1'b0, 8'd1);
        send_word(OP_READ_BIN, 2'd0, 1'b0, 8'd2);
        send_word(OP_READ_BIN, 2'd0, 1'b0, 8'd0);
        set_size(4'd0);
        send_word(OP_BASE, 2'd2, 1'b1, 8'd0);
        send_word(OP_COMBINE, 2'd0, 1'b0, 8'd0);
        send_word(OP_READ_BIN, 2'd0, 1'b0, 8'd1);
        set_size(4'd15);
        send_word(OP_BASE, 2'd1, 1'b0, 8'd0);
        send_word(OP_COMBINE, 2'd0, 1'b0, 8'd0);
    endtask

    task automatic test_saturation();
        set_size(4'd1);
        for (int i = 0; i < 300; i++)
        begin
            send_word(OP_BASE, 2'd0, 1'b0, 8'd0);
        end
        send_word(OP_BASE, 2'd3, 1'b0, 8'd0);
        send_word(OP_COMBINE, 2'd0, 1'b0, 8'd0);
        send_word(OP_READ_BIN, 2'd0, 1'b0, 8'd255);
    endtask

    task automatic random_reads(input int n_words, input logic [3:0] k);
        set_size(k);
        for (int i = 0; i < n_words; i++)
        begin
            if (($urandom % 40) == 0)
            begin
                send_word(op_t'($urandom_range(1, 3)), 2'($urandom), 1'($urandom),
                          8'($urandom));
            end
            else
            begin
                send_word(OP_BASE, 2'($urandom), ($urandom % 12) == 0, 8'($urandom));
            end
        end
        send_word(OP_COMBINE, 2'd0, 1'b0, 8'd0);
        read_all_bins();
    endtask

    task automatic test_random();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_reads(300, 4'd3);
        send_idle_pct = 76;
        random_reads(300, 4'd4);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        random_reads(250, 4'd5);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        random_reads(200, 4'd8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_reads(150, 4'd6);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        window = '0;
        read_len = '0;
        occurrences = '0;
        distinct_count = '0;
        size_reg = 4'd8;
        for (int i = 0; i < 65536; i++)
        begin
            counts[i] = '0;
        end
        for (int b = 0; b < 256; b++)
        begin
            freq_bins[b] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_random();
        drain();
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("PASS kmer_count_canonical_histogram");
        end
        else
        begin
            $display("FAIL kmer_count_canonical_histogram");
        end
        $finish;
    end

    initial
    begin
        #200ms;
        $display("FAIL kmer_count_canonical_histogram");
        $finish;
    end
endmodule
